@@ design/xoro_pkg.sv @@
// shared types, constants and helpers for the xoroshiro128+ generator
`default_nettype none

package xoro_pkg;

    localparam int unsigned WORD_W        = 64;
    localparam int unsigned HALF_W        = WORD_W / 2;
    localparam int unsigned WARMUP_STEPS  = 8;
    localparam int unsigned SEED_WORDS    = 3;

    localparam logic [WORD_W-1:0] SM_GAMMA = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [WORD_W-1:0] SM_MUL1  = 64'hBF58_476D_1CE4_E5B9;
    localparam logic [WORD_W-1:0] SM_MUL2  = 64'h94D0_49BB_1331_11EB;

    localparam int unsigned ROT_A   = 55;
    localparam int unsigned ROT_B   = 36;
    localparam int unsigned SHIFT_B = 14;
    localparam int unsigned SM_SH1  = 30;
    localparam int unsigned SM_SH2  = 27;
    localparam int unsigned SM_SH3  = 31;

    // input mode codes
    localparam logic MODE_RESEED = 1'b0;
    localparam logic MODE_DRAW   = 1'b1;

    // partial product selection of the shared 32x32 multiplier
    typedef enum logic [1:0] {
        PH_LO_LO = 2'd0,
        PH_LO_HI = 2'd1,
        PH_HI_LO = 2'd2
    } mul_phase_t;

    // multiplier constant selection
    typedef enum logic {
        MSEL_FIRST  = 1'b0,
        MSEL_SECOND = 1'b1
    } mul_sel_t;

    // commands from controller to datapath
    typedef struct packed {
        logic       load_seed;
        logic       seed_zero;
        logic       mix_add;
        logic       mul_en;
        mul_phase_t mul_phase;
        mul_sel_t   mul_sel;
        logic       store_x;
        logic       store_y;
        logic       step;
        logic       capture;
    } xoro_cmd_t;

    function automatic logic [WORD_W-1:0] rotl64(input logic [WORD_W-1:0] v,
                                                 input int unsigned k);
        return (v << k) | (v >> (WORD_W - k));
    endfunction

endpackage

`default_nettype wire

@@ design/xoro_dpath.sv @@
// datapath: state words, splitmix64 registers, shared multiplier, output register
`default_nettype none

module xoro_dpath (
    input  wire logic                      aclk,
    input  wire xoro_pkg::xoro_cmd_t       cmd,
    input  wire logic [xoro_pkg::WORD_W-1:0] seed,
    output logic [xoro_pkg::WORD_W-1:0]    value
);
    import xoro_pkg::*;

    logic [WORD_W-1:0] x_reg, x_next;
    logic [WORD_W-1:0] y_reg, y_next;
    logic [WORD_W-1:0] ctr_reg, ctr_next;
    logic [WORD_W-1:0] z_reg, z_next;
    logic [WORD_W-1:0] acc_reg, acc_next;
    logic [WORD_W-1:0] value_reg, value_next;

    logic [WORD_W-1:0] ctr_inc;
    logic [WORD_W-1:0] mul_const;
    logic [HALF_W-1:0] mul_a;
    logic [HALF_W-1:0] mul_b;
    logic [WORD_W-1:0] prod;
    logic [WORD_W-1:0] prod_shl;
    logic [WORD_W-1:0] mul_sum;
    logic [WORD_W-1:0] mix_val;
    logic [WORD_W-1:0] step_b;
    logic [WORD_W-1:0] step_x;
    logic [WORD_W-1:0] step_y;

    // splitmix64 counter advance
    assign ctr_inc = ctr_reg + SM_GAMMA;

    // shared 32x32 multiplier operand selection
    assign mul_const = (cmd.mul_sel == MSEL_SECOND) ? SM_MUL2 : SM_MUL1;

    always_comb begin
        mul_a = z_reg[HALF_W-1:0];
        mul_b = mul_const[HALF_W-1:0];
        unique case (cmd.mul_phase)
            PH_LO_LO: begin
                mul_a = z_reg[HALF_W-1:0];
                mul_b = mul_const[HALF_W-1:0];
            end
            PH_LO_HI: begin
                mul_a = z_reg[HALF_W-1:0];
                mul_b = mul_const[WORD_W-1:HALF_W];
            end
            PH_HI_LO: begin
                mul_a = z_reg[WORD_W-1:HALF_W];
                mul_b = mul_const[HALF_W-1:0];
            end
            default: begin
                mul_a = z_reg[HALF_W-1:0];
                mul_b = mul_const[HALF_W-1:0];
            end
        endcase
    end

    assign prod     = WORD_W'(mul_a) * WORD_W'(mul_b);
    assign prod_shl = {prod[HALF_W-1:0], {HALF_W{1'b0}}};
    assign mul_sum  = acc_reg + prod_shl;

    // xor-shift that follows each multiplication
    assign mix_val = (cmd.mul_sel == MSEL_SECOND) ? (mul_sum ^ (mul_sum >> SM_SH3))
                                                  : (mul_sum ^ (mul_sum >> SM_SH2));

    // xoroshiro128+ state step
    assign step_b = y_reg ^ x_reg;
    assign step_x = rotl64(x_reg, ROT_A) ^ step_b ^ (step_b << SHIFT_B);
    assign step_y = rotl64(step_b, ROT_B);

    // next-value selection
    always_comb begin
        x_next     = x_reg;
        y_next     = y_reg;
        ctr_next   = ctr_reg;
        z_next     = z_reg;
        acc_next   = acc_reg;
        value_next = value_reg;
        if (cmd.load_seed) begin
            ctr_next = cmd.seed_zero ? '0 : seed;
        end
        if (cmd.mix_add) begin
            ctr_next = ctr_inc;
            z_next   = ctr_inc ^ (ctr_inc >> SM_SH1);
        end
        if (cmd.mul_en) begin
            unique case (cmd.mul_phase)
                PH_LO_LO: acc_next = prod;
                PH_LO_HI: acc_next = mul_sum;
                PH_HI_LO: z_next   = mix_val;
                default:  acc_next = acc_reg;
            endcase
        end
        if (cmd.store_x) begin
            x_next = mix_val;
        end
        if (cmd.store_y) begin
            y_next = mix_val;
        end
        if (cmd.capture) begin
            value_next = x_reg + y_reg;
        end
        if (cmd.step) begin
            x_next = step_x;
            y_next = step_y;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg     <= x_next;
        y_reg     <= y_next;
        ctr_reg   <= ctr_next;
        z_reg     <= z_next;
        acc_reg   <= acc_next;
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

`default_nettype wire

@@ design/xoro_ctrl.sv @@
// controller: handshakes, seeding sequence and warm-up steps
`default_nettype none

module xoro_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic                s_mode,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output xoro_pkg::xoro_cmd_t      cmd
);
    import xoro_pkg::*;

    localparam int unsigned WARM_W = $clog2(WARMUP_STEPS);
    localparam int unsigned WORD_CNT_W = $clog2(SEED_WORDS);
    localparam logic [WARM_W-1:0] WARM_LAST = WARM_W'(WARMUP_STEPS - 1);
    localparam logic [WORD_CNT_W-1:0] WORD_LAST = WORD_CNT_W'(SEED_WORDS - 1);
    localparam logic [WORD_CNT_W-1:0] WORD_X = WORD_CNT_W'(1);

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_ADD,
        ST_MUL,
        ST_WARM
    } state_t;

    state_t                state_reg, state_next;
    mul_phase_t            phase_reg, phase_next;
    mul_sel_t              sel_reg, sel_next;
    logic [WORD_CNT_W-1:0] word_reg, word_next;
    logic [WARM_W-1:0]     warm_reg, warm_next;
    logic                  m_valid_reg, m_valid_next;

    logic in_xfer;
    logic mul_last;

    assign s_ready  = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign in_xfer  = s_valid && s_ready;
    assign m_valid  = m_valid_reg;
    assign mul_last = (phase_reg == PH_HI_LO) && (sel_reg == MSEL_SECOND);

    // next state and commands
    always_comb begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        sel_next     = sel_reg;
        word_next    = word_reg;
        warm_next    = warm_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        cmd.mul_phase = phase_reg;
        cmd.mul_sel   = sel_reg;
        unique case (state_reg)
            ST_INIT: begin
                cmd.load_seed = 1'b1;
                cmd.seed_zero = 1'b1;
                word_next     = '0;
                state_next    = ST_ADD;
            end
            ST_IDLE: begin
                if (in_xfer) begin
                    if (s_mode == MODE_RESEED) begin
                        cmd.load_seed = 1'b1;
                        word_next     = '0;
                        state_next    = ST_ADD;
                    end else begin
                        cmd.capture  = 1'b1;
                        cmd.step     = 1'b1;
                        m_valid_next = 1'b1;
                    end
                end
            end
            ST_ADD: begin
                cmd.mix_add = 1'b1;
                phase_next  = PH_LO_LO;
                sel_next    = MSEL_FIRST;
                state_next  = ST_MUL;
            end
            ST_MUL: begin
                cmd.mul_en = 1'b1;
                priority if (phase_reg == PH_LO_LO) begin
                    phase_next = PH_LO_HI;
                end else if (phase_reg == PH_LO_HI) begin
                    phase_next = PH_HI_LO;
                end else if (!mul_last) begin
                    phase_next = PH_LO_LO;
                    sel_next   = MSEL_SECOND;
                end else begin
                    // one splitmix64 output ready: first is dropped
                    cmd.store_x = (word_reg == WORD_X);
                    cmd.store_y = (word_reg == WORD_LAST);
                    if (word_reg == WORD_LAST) begin
                        warm_next  = '0;
                        state_next = ST_WARM;
                    end else begin
                        word_next  = word_reg + 1'b1;
                        state_next = ST_ADD;
                    end
                end
            end
            ST_WARM: begin
                cmd.step  = 1'b1;
                warm_next = warm_reg + 1'b1;
                if (warm_reg == WARM_LAST) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_INIT;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_INIT;
            phase_reg   <= PH_LO_LO;
            sel_reg     <= MSEL_FIRST;
            word_reg    <= '0;
            warm_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            sel_reg     <= sel_next;
            word_reg    <= word_next;
            warm_reg    <= warm_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

`default_nettype wire

@@ design/xoroshiro128_plus_generator_core.sv @@
// top level of the xoroshiro128+ generator with splitmix64 seeding
// A draw transfer (mode 1) returns x + y and steps the state in the same cycle, so
// draws run at one per clock while the result side keeps up. While a value waits in
// the output register the input is stalled; a new draw is taken in the same cycle
// that the waiting value is taken. A reseed transfer (mode 0)
// gives no result and keeps the block busy while it derives three splitmix64 words
// (each an add step, then two 64-bit multiplies done as three partial products
// on the one shared 32x32 multiplier) and runs 8 warm-up steps. After reset the
// block seeds itself with zero the same way before s_ready rises.
`default_nettype none

module xoroshiro128_plus_generator_core (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic                        s_mode,
    input  wire logic [xoro_pkg::WORD_W-1:0] s_seed,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic [xoro_pkg::WORD_W-1:0]      m_value
);
    import xoro_pkg::*;

    xoro_cmd_t cmd;

    // sequencing and handshakes
    xoro_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_mode  (s_mode),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    // state words and arithmetic
    xoro_dpath u_dpath (
        .aclk  (aclk),
        .cmd   (cmd),
        .seed  (s_seed),
        .value (m_value)
    );

endmodule

`default_nettype wire

@@ design/xoro_checker.sv @@
// port-level checks for the xoroshiro128+ generator, bound to the top level
`default_nettype none

module xoro_checker (
    input wire logic                        aclk,
    input wire logic                        aresetn,
    input wire logic                        s_valid,
    input wire logic                        s_ready,
    input wire logic                        s_mode,
    input wire logic                        m_valid,
    input wire logic                        m_ready,
    input wire logic [xoro_pkg::WORD_W-1:0] m_value
);
    import xoro_pkg::*;

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_value))
        else $error("result changed while stalled");

    // a draw transfer always yields a result next cycle
    a_draw_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_mode == MODE_DRAW) |=> m_valid)
        else $error("draw gave no result");

    // a reseed transfer yields no result and makes the block busy
    a_reseed_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_mode == MODE_RESEED) |=> !m_valid && !s_ready)
        else $error("reseed produced a result or did not go busy");

    // block seeds itself after reset before taking any transfer
    a_reset_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(aresetn) |-> !s_ready && !m_valid)
        else $error("ready right after reset");

endmodule

bind xoroshiro128_plus_generator_core xoro_checker u_xoro_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_mode  (s_mode),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_value (m_value)
);

`default_nettype wire
